// File: design/acm_pkg.sv
// Shared types, constants and AES byte functions for the AES CBC/CTR mode engine.
// Used by acm_round, aes_cbc_ctr_mode_engine and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package acm_pkg;

  // Block and key schedule geometry.
  localparam int BLOCK_W    = 128;
  localparam int WORD_W     = 32;
  localparam int RK_DEPTH   = 15;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int TDATA_W    = 136;
  localparam int CNT_W      = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HI    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LO    = 3'd7;

  // Mode codes.
  localparam logic [1:0] MODE_CBC_ENC = 2'd0;
  localparam logic [1:0] MODE_CBC_DEC = 2'd1;
  localparam logic [1:0] MODE_CTR     = 2'd2;

  // Key size codes.
  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_KEXP,
    ST_IDLE,
    ST_HDR,
    ST_WAIT,
    ST_RUN,
    ST_EMIT
  } state_t;

  // Control for one pass through the round unit.
  typedef struct packed {
    logic inv;
    logic first;
    logic last;
  } round_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] ISBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // S-box applied to the four bytes of a word.
  function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte substitution and row shift over the block; byte 0 is the top byte.
  function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s,
                                                   input logic inv);
    logic [BLOCK_W-1:0] t;
    logic [7:0]         v;
    int                 src;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
        v   = s[BLOCK_W-1-8*(4*src+r) -: 8];
        t[BLOCK_W-1-8*(4*c+r) -: 8] = inv ? ISBOX[v] : SBOX[v];
      end
    end
    sub_shift = t;
  endfunction

  // Column mix of one word, forward or inverse.
  function automatic logic [WORD_W-1:0] mix_col(input logic [WORD_W-1:0] w, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m0 [4];
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    for (int k = 0; k < 4; k++) begin
      a[k]  = w[WORD_W-1-8*k -: 8];
      x2[k] = xt(a[k]);
      x4[k] = xt(x2[k]);
      x8[k] = xt(x4[k]);
      // m0..m3 hold the products by 2,3,1,1 or by 14,11,13,9.
      m0[k] = inv ? (x8[k] ^ x4[k] ^ x2[k]) : x2[k];
      m1[k] = inv ? (x8[k] ^ x2[k] ^ a[k]) : (x2[k] ^ a[k]);
      m2[k] = inv ? (x8[k] ^ x4[k] ^ a[k]) : a[k];
      m3[k] = inv ? (x8[k] ^ a[k]) : a[k];
    end
    mix_col = {m0[0] ^ m1[1] ^ m2[2] ^ m3[3],
               m3[0] ^ m0[1] ^ m1[2] ^ m2[3],
               m2[0] ^ m3[1] ^ m0[2] ^ m1[3],
               m1[0] ^ m2[1] ^ m3[2] ^ m0[3]};
  endfunction

  // Column mix over the whole block.
  function automatic logic [BLOCK_W-1:0] mix(input logic [BLOCK_W-1:0] s, input logic inv);
    logic [BLOCK_W-1:0] t;
    for (int c = 0; c < 4; c++) begin
      t[BLOCK_W-1-WORD_W*c -: WORD_W] = mix_col(s[BLOCK_W-1-WORD_W*c -: WORD_W], inv);
    end
    mix = t;
  endfunction

endpackage

// File: design/acm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the expanded round keys of the AES mode engine; no dependencies.
`timescale 1ns / 1ps

module acm_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/acm_round.sv
// One AES round, forward or inverse, including the initial and final variants.
// Depends on acm_pkg for the S-boxes and column mix.
`timescale 1ns / 1ps

module acm_round (
  input  logic [acm_pkg::BLOCK_W-1:0] state_in,
  input  logic [acm_pkg::BLOCK_W-1:0] round_key,
  input  acm_pkg::round_ctl_t         ctl,
  output logic [acm_pkg::BLOCK_W-1:0] state_out
);
  import acm_pkg::*;

  logic [BLOCK_W-1:0] ss;
  logic [BLOCK_W-1:0] ark;

  // Forward: mix comes before the key add; inverse: mix follows the key add.
  always_comb begin
    ss  = sub_shift(state_in, ctl.inv);
    ark = '0;
    if (ctl.first) begin
      state_out = state_in ^ round_key;
    end else if (ctl.last) begin
      state_out = ss ^ round_key;
    end else if (ctl.inv) begin
      ark       = ss ^ round_key;
      state_out = mix(ark, 1'b1);
    end else begin
      state_out = mix(ss, 1'b0) ^ round_key;
    end
  end

endmodule

// File: design/aes_cbc_ctr_mode_engine.sv
// Top level of the AES CBC/CTR mode engine: config registers, key expansion and sequencer.
// Depends on acm_pkg, acm_ram (round key store) and acm_round (shared round unit).
`timescale 1ns / 1ps

// One 128-bit block is taken per item and runs through a single shared AES
// round unit, one round per cycle. A cipher pass goes through accept, a round
// key read, the initial key add, the Nr rounds and an output step. CBC encrypt
// adds a header step for the IV on a first block and a second pass for the
// extra padding block after a full last block. in_tready is low while an item
// is in work. After reset and after any write of a key word or the key size,
// the key schedule is rebuilt one word per cycle (44, 52 or 60 words) before
// items are taken. in_tdata: block_hi, block_lo, byte_count; in_tuser is
// first_block and in_tlast is last_block. out_tuser is is_header and out_tlast
// is run_end.

module aes_cbc_ctr_mode_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [acm_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [acm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input item channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [acm_pkg::TDATA_W-1:0]    in_tdata,   // block_hi, block_lo, byte_count, zeros
  input  logic                           in_tuser,   // first_block
  input  logic                           in_tlast,   // last_block
  // Result channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [acm_pkg::TDATA_W-1:0]    out_tdata,  // out_hi, out_lo, out_bytes, zeros
  output logic                           out_tuser,  // is_header
  output logic                           out_tlast   // run_end
);
  import acm_pkg::*;

  localparam int RK_AW = $clog2(RK_DEPTH);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] key_r [4];
  logic [1:0]            key_size_r;
  logic [1:0]            mode_r;
  logic [CFG_DATA_W-1:0] iv_hi_r;
  logic [CFG_DATA_W-1:0] iv_lo_r;

  // Sequencer and data path registers.
  state_t             state_r, state_nxt;
  logic [5:0]         ki_r, ki_nxt;
  logic [2:0]         km_r, km_nxt;
  logic [7:0]         rc_r, rc_nxt;
  logic [WORD_W-1:0]  win_r [8];
  logic [WORD_W-1:0]  win_nxt [8];
  logic [3*WORD_W-1:0] acc_r, acc_nxt;
  logic [BLOCK_W-1:0] blk_r, blk_nxt;
  logic [BLOCK_W-1:0] chain_r, chain_nxt;
  logic [BLOCK_W-1:0] st_r, st_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               last_r, last_nxt;
  logic               extra_r, extra_nxt;
  logic [3:0]         step_r, step_nxt;
  logic [RK_AW-1:0]   kidx_r, kidx_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [BLOCK_W-1:0] out_data_r, out_data_nxt;
  logic [CNT_W-1:0]   out_bytes_r, out_bytes_nxt;
  logic               out_hdr_r, out_hdr_nxt;
  logic               out_last_r, out_last_nxt;

  // Key schedule geometry.
  logic [3:0]         nr;
  logic [3:0]         nk;
  logic               inv;

  // Key expansion word path.
  logic [CFG_DATA_W-1:0] kw;
  logic [WORD_W-1:0]  t_word;
  logic [WORD_W-1:0]  back_word;
  logic [WORD_W-1:0]  new_word;
  logic               rk_we;

  // Round unit hookup.
  logic [BLOCK_W-1:0] rk_data;
  logic [BLOCK_W-1:0] round_in;
  logic [BLOCK_W-1:0] round_out;
  round_ctl_t         rctl;

  // Input item unpacking.
  logic [BLOCK_W-1:0] in_block;
  logic [CNT_W-1:0]   in_cnt;
  logic [BLOCK_W-1:0] in_chain;
  logic [BLOCK_W-1:0] padded;

  // Result assembly.
  logic [BLOCK_W-1:0] dec_data;
  logic [BLOCK_W-1:0] ctr_data;
  logic [7:0]         pad_byte;
  logic [CNT_W-1:0]   dec_bytes;
  logic               out_free;

  assign nr  = (key_size_r == KS_128) ? 4'd10 : ((key_size_r == KS_192) ? 4'd12 : 4'd14);
  assign nk  = nr - 4'd6;
  assign inv = (mode_r == MODE_CBC_DEC);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W-BLOCK_W-CNT_W){1'b0}}, out_bytes_r,
                       out_data_r[CFG_DATA_W-1:0], out_data_r[BLOCK_W-1:CFG_DATA_W]};
  assign out_tuser  = out_hdr_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        key_r[k] <= '0;
      end
      key_size_r <= KS_128;
      mode_r     <= MODE_CBC_ENC;
      iv_hi_r    <= '0;
      iv_lo_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KEY0:     key_r[0]   <= cfg_wdata;
        REG_KEY1:     key_r[1]   <= cfg_wdata;
        REG_KEY2:     key_r[2]   <= cfg_wdata;
        REG_KEY3:     key_r[3]   <= cfg_wdata;
        REG_KEY_SIZE: key_size_r <= cfg_wdata[1:0];
        REG_MODE:     mode_r     <= cfg_wdata[1:0];
        REG_IV_HI:    iv_hi_r    <= cfg_wdata;
        REG_IV_LO:    iv_lo_r    <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // Key expansion: one schedule word per cycle from a window of the last eight.
  always_comb begin
    kw = key_r[ki_r[2:1]];
    case (nk)
      4'd4:    back_word = win_r[4];
      4'd6:    back_word = win_r[2];
      default: back_word = win_r[0];
    endcase
    if (km_r == 3'd0) begin
      t_word = sub_word({win_r[7][23:0], win_r[7][31:24]}) ^ {rc_r, 24'h0};
    end else if ((nk == 4'd8) && (km_r == 3'd4)) begin
      t_word = sub_word(win_r[7]);
    end else begin
      t_word = win_r[7];
    end
    if ({2'b00, ki_r} < {4'd0, nk}) begin
      new_word = ki_r[0] ? kw[WORD_W-1:0] : kw[CFG_DATA_W-1:WORD_W];
    end else begin
      new_word = back_word ^ t_word;
    end
  end

  assign rk_we = (state_r == ST_KEXP) && (ki_r[1:0] == 2'b11);

  acm_ram #(
    .WIDTH (BLOCK_W),
    .DEPTH (RK_DEPTH)
  ) u_rk_ram (
    .clk     (clk),
    .wr_en   (rk_we),
    .wr_addr (ki_r[5:2]),
    .wr_data ({acc_r, new_word}),
    .rd_addr (kidx_r),
    .rd_data (rk_data)
  );

  // Round unit input and control for the current step.
  always_comb begin
    case (mode_r)
      MODE_CBC_ENC: round_in = blk_r ^ chain_r;
      MODE_CBC_DEC: round_in = blk_r;
      default:      round_in = chain_r;
    endcase
    if (step_r != 4'd0) begin
      round_in = st_r;
    end
    rctl.inv   = inv;
    rctl.first = (step_r == 4'd0);
    rctl.last  = (step_r == nr);
  end

  acm_round u_round (
    .state_in  (round_in),
    .round_key (rk_data),
    .ctl       (rctl),
    .state_out (round_out)
  );

  // Input unpacking, chain selection and PKCS#7 padding of a short last block.
  always_comb begin
    in_block = {in_tdata[CFG_DATA_W-1:0], in_tdata[BLOCK_W-1:CFG_DATA_W]};
    in_cnt   = (in_tdata[BLOCK_W+CNT_W-1:BLOCK_W] > 5'd16) ? 5'd16
                                                          : in_tdata[BLOCK_W+CNT_W-1:BLOCK_W];
    in_chain = in_tuser ? {iv_hi_r, iv_lo_r} : chain_r;
    padded   = in_block;
    if (in_tlast) begin
      for (int b = 0; b < 16; b++) begin
        if (5'(b) >= in_cnt) begin
          padded[BLOCK_W-1-8*b -: 8] = 8'd16 - {3'b000, in_cnt};
        end
      end
    end
  end

  // Result values for decrypt and counter mode.
  always_comb begin
    dec_data = st_r ^ chain_r;
    pad_byte = dec_data[7:0];
    if (!last_r || (pad_byte == 8'd0)) begin
      dec_bytes = 5'd16;
    end else if (pad_byte > 8'd16) begin
      dec_bytes = 5'd0;
    end else begin
      dec_bytes = 5'(8'd16 - pad_byte);
    end
    ctr_data = st_r ^ blk_r;
    for (int b = 0; b < 16; b++) begin
      if (5'(b) >= cnt_r) begin
        ctr_data[BLOCK_W-1-8*b -: 8] = 8'h00;
      end
    end
  end

  // Sequencer: next state and data path updates.
  always_comb begin
    state_nxt     = state_r;
    ki_nxt        = ki_r;
    km_nxt        = km_r;
    rc_nxt        = rc_r;
    win_nxt       = win_r;
    acc_nxt       = acc_r;
    blk_nxt       = blk_r;
    chain_nxt     = chain_r;
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    extra_nxt     = extra_r;
    step_nxt      = step_r;
    kidx_nxt      = kidx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_bytes_nxt = out_bytes_r;
    out_hdr_nxt   = out_hdr_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_KEXP: begin
        for (int k = 0; k < 7; k++) begin
          win_nxt[k] = win_r[k+1];
        end
        win_nxt[7] = new_word;
        acc_nxt    = {acc_r[2*WORD_W-1:0], new_word};
        if ({2'b00, ki_r} >= {4'd0, nk} && km_r == 3'd0) begin
          rc_nxt = xt(rc_r);
        end
        km_nxt = ({1'b0, km_r} == nk - 4'd1) ? 3'd0 : km_r + 3'd1;
        ki_nxt = ki_r + 6'd1;
        if (ki_r == {nr, 2'b11}) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_tvalid && (mode_r == MODE_CBC_ENC || mode_r == MODE_CBC_DEC ||
                          mode_r == MODE_CTR)) begin
          blk_nxt   = (mode_r == MODE_CBC_ENC) ? padded : in_block;
          chain_nxt = in_chain;
          cnt_nxt   = in_cnt;
          last_nxt  = in_tlast;
          extra_nxt = (mode_r == MODE_CBC_ENC) && in_tlast && (in_cnt == 5'd16);
          step_nxt  = 4'd0;
          kidx_nxt  = inv ? nr : '0;
          state_nxt = ((mode_r == MODE_CBC_ENC) && in_tuser) ? ST_HDR : ST_WAIT;
        end
      end

      ST_HDR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = chain_r;
          out_bytes_nxt = 5'd16;
          out_hdr_nxt   = 1'b1;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_WAIT;
        end
      end

      ST_WAIT: begin
        kidx_nxt  = inv ? nr - 4'd1 : 4'd1;
        step_nxt  = 4'd0;
        state_nxt = ST_RUN;
      end

      ST_RUN: begin
        st_nxt   = round_out;
        step_nxt = step_r + 4'd1;
        if (step_r + 4'd1 < nr) begin
          kidx_nxt = inv ? kidx_r - 4'd1 : kidx_r + 4'd1;
        end
        if (step_r == nr) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hdr_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
          case (mode_r)
            MODE_CBC_ENC: begin
              out_data_nxt  = st_r;
              out_bytes_nxt = 5'd16;
              chain_nxt     = st_r;
              if (extra_r) begin
                // Full last block: a block of padding bytes follows.
                out_last_nxt = 1'b0;
                extra_nxt    = 1'b0;
                blk_nxt      = {16{8'h10}};
                kidx_nxt     = '0;
                step_nxt     = 4'd0;
                state_nxt    = ST_WAIT;
              end
            end
            MODE_CBC_DEC: begin
              out_data_nxt  = dec_data;
              out_bytes_nxt = dec_bytes;
              chain_nxt     = blk_r;
            end
            default: begin
              out_data_nxt  = ctr_data;
              out_bytes_nxt = cnt_r;
              chain_nxt     = chain_r + 128'd1;
            end
          endcase
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // A key or key size write restarts the schedule.
    if (cfg_we && (cfg_addr == REG_KEY0 || cfg_addr == REG_KEY1 || cfg_addr == REG_KEY2 ||
                   cfg_addr == REG_KEY3 || cfg_addr == REG_KEY_SIZE)) begin
      state_nxt = ST_KEXP;
      ki_nxt    = '0;
      km_nxt    = '0;
      rc_nxt    = 8'h01;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_KEXP;
      ki_r        <= '0;
      km_r        <= '0;
      rc_r        <= 8'h01;
      chain_r     <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      kidx_r      <= '0;
      extra_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ki_r        <= ki_nxt;
      km_r        <= km_nxt;
      rc_r        <= rc_nxt;
      chain_r     <= chain_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      kidx_r      <= kidx_nxt;
      extra_r     <= extra_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    win_r       <= win_nxt;
    acc_r       <= acc_nxt;
    blk_r       <= blk_nxt;
    st_r        <= st_nxt;
    cnt_r       <= cnt_nxt;
    last_r      <= last_nxt;
    out_data_r  <= out_data_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_hdr_r   <= out_hdr_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

// File: tb/sv/aes_cbc_ctr_mode_engine_tb.sv
// Self-checking testbench for the AES CBC/CTR mode engine: directed rows, then random messages.
// Depends on acm_pkg for register and mode codes and on the aes_cbc_ctr_mode_engine RTL.
`timescale 1ns / 1ps

module aes_cbc_ctr_mode_engine_tb;
  import acm_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE     = 80;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  nbytes;
    logic        hdr;
    logic        fin;
  } cipher_res_t;

  typedef struct {
    logic [1:0]  mode;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        first;
    logic        last;
    logic [4:0]  cnt;
    logic        known;
    logic [127:0] known_blk;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata;   // block_hi, block_lo, byte_count, zeros
  logic                  in_tuser;   // first_block
  logic                  in_tlast;   // last_block
  logic                  out_tvalid;
  logic                  out_tready;
  logic [TDATA_W-1:0]    out_tdata;  // out_hi, out_lo, out_bytes, zeros
  logic                  out_tuser;  // is_header
  logic                  out_tlast;  // run_end

  aes_cbc_ctr_mode_engine uut (.*);

  // Predictor state.
  logic [7:0]   fwd_sbox [256];
  logic [7:0]   inv_sbox [256];
  logic [31:0]  sched [60];
  logic [63:0]  key_reg [4];
  logic [1:0]   ksize_reg;
  logic [1:0]   mode_reg;
  logic [127:0] iv_reg;
  logic [127:0] chain_val;
  logic [127:0] last_pred;
  cipher_res_t  pending_q [$];

  int errors;
  int items_sent;
  int results_seen;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_left = 0;
  int quiet_cycles = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = gf_xtime(a);
    end
    return r;
  endfunction

  function automatic int rounds_for(input logic [1:0] ks);
    return (ks == 2'd0) ? 10 : ((ks == 2'd1) ? 12 : 14);
  endfunction

  function automatic logic [127:0] add_round(input logic [127:0] s, input int r);
    for (int c = 0; c < 4; c++) s[127-32*c -: 32] ^= sched[(4*r + c) % 60];
    return s;
  endfunction

  function automatic logic [127:0] sub_rows(input logic [127:0] s, input bit inv);
    logic [127:0] t;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? (c + 4 - r) % 4 : (c + r) % 4;
        t[127-8*(4*c+r) -: 8] = inv ? inv_sbox[s[127-8*(4*src+r) -: 8]]
                                    : fwd_sbox[s[127-8*(4*src+r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s, input bit inv);
    logic [7:0] a [4];
    logic [7:0] m [4];
    logic [127:0] t;
    if (inv) begin
      m = '{8'd14, 8'd11, 8'd13, 8'd9};
    end else begin
      m = '{8'd2, 8'd3, 8'd1, 8'd1};
    end
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) a[k] = s[127-8*(4*c+k) -: 8];
      // Row k uses the circulant matrix rotated right by k.
      for (int k = 0; k < 4; k++)
        t[127-8*(4*c+k) -: 8] = gf_mul(a[0], m[(4-k)%4]) ^ gf_mul(a[1], m[(5-k)%4]) ^
                                gf_mul(a[2], m[(6-k)%4]) ^ gf_mul(a[3], m[(7-k)%4]);
    end
    return t;
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] s);
    int nr;
    nr = rounds_for(ksize_reg);
    s = add_round(s, 0);
    for (int r = 1; r < nr; r++) s = add_round(mix_cols(sub_rows(s, 0), 0), r);
    return add_round(sub_rows(s, 0), nr);
  endfunction

  function automatic logic [127:0] aes_decrypt(input logic [127:0] s);
    int nr;
    nr = rounds_for(ksize_reg);
    s = add_round(s, nr);
    for (int r = nr - 1; r >= 1; r--) s = mix_cols(add_round(sub_rows(s, 1), r), 1);
    return add_round(sub_rows(s, 1), 0);
  endfunction

  // Key schedule, rebuilt after any key or key size write.
  function automatic void rebuild_schedule();
    int nr, nk, total;
    logic [7:0]  rc;
    logic [31:0] t;
    nr = rounds_for(ksize_reg);
    nk = nr - 6;
    total = 4 * (nr + 1);
    rc = 8'h01;
    for (int i = 0; i < 60; i++) sched[i] = '0;
    for (int i = 0; i < nk; i++) sched[i] = i[0] ? key_reg[i>>1][31:0] : key_reg[i>>1][63:32];
    for (int i = nk; i < total; i++) begin
      t = sched[i-1];
      if (i % nk == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_sbox[t[31:24]], fwd_sbox[t[23:16]], fwd_sbox[t[15:8]], fwd_sbox[t[7:0]]};
        t ^= {rc, 24'h0};
        rc = gf_xtime(rc);
      end else if (nk == 8 && i % nk == 4) begin
        t = {fwd_sbox[t[31:24]], fwd_sbox[t[23:16]], fwd_sbox[t[15:8]], fwd_sbox[t[7:0]]};
      end
      sched[i] = sched[i-nk] ^ t;
    end
  endfunction

  function automatic void push_result(input logic [127:0] blk, input logic [4:0] nb,
                                      input logic hdr);
    cipher_res_t e;
    e.hi = blk[127:64];
    e.lo = blk[63:0];
    e.nbytes = nb;
    e.hdr = hdr;
    e.fin = 1'b0;
    pending_q.push_back(e);
    last_pred = blk;
  endfunction

  // Expected results of one accepted item.
  function automatic void predict_item(input logic [127:0] blk, input logic first,
                                       input logic last, input logic [4:0] cnt_in);
    int cnt, nblk;
    logic [127:0] x;
    logic [7:0] p;
    cnt = (cnt_in > 16) ? 16 : cnt_in;
    if (first) chain_val = iv_reg;
    case (mode_reg)
      MODE_CBC_ENC: begin
        nblk = 1;
        if (first) push_result(chain_val, 5'd16, 1'b1);
        if (last) begin
          if (cnt < 16) begin
            for (int i = cnt; i < 16; i++) blk[127-8*i -: 8] = 8'(16 - cnt);
          end else begin
            nblk = 2;
          end
        end
        for (int b = 0; b < nblk; b++) begin
          if (b == 1) blk = {16{8'h10}};
          chain_val = aes_encrypt(blk ^ chain_val);
          push_result(chain_val, 5'd16, 1'b0);
        end
      end
      MODE_CBC_DEC: begin
        x = aes_decrypt(blk) ^ chain_val;
        p = x[7:0];
        chain_val = blk;
        if (!last || p == 0) push_result(x, 5'd16, 1'b0);
        else if (p > 16) push_result(x, 5'd0, 1'b0);
        else push_result(x, 5'(16 - p), 1'b0);
      end
      MODE_CTR: begin
        x = aes_encrypt(chain_val) ^ blk;
        for (int i = cnt; i < 16; i++) x[127-8*i -: 8] = 8'h00;
        chain_val = chain_val + 128'd1;
        push_result(x, 5'(cnt), 1'b0);
      end
      default: return;
    endcase
    pending_q[$].fin = 1'b1;
  endfunction

  // Register write; the predictor follows at the same edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(posedge clk);
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
        key_reg[idx] = val;
        rebuild_schedule();
      end
      REG_KEY_SIZE: begin
        ksize_reg = val[1:0];
        rebuild_schedule();
      end
      REG_MODE: mode_reg = val[1:0];
      REG_IV_HI: iv_reg[127:64] = val;
      REG_IV_LO: iv_reg[63:0] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Wait until every expected result has arrived, then let the block settle.
  task automatic drain();
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Offer one item with random gaps before it; returns once it is accepted.
  task automatic send_item(input logic [127:0] blk, input logic first, input logic last,
                           input logic [4:0] cnt);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {3'b000, cnt, blk[63:0], blk[127:64]};
    in_tuser = first;
    in_tlast = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_item(blk, first, last, cnt);
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic load_setting(input logic [1:0] ks, input logic [1:0] md,
                              input logic [255:0] key, input logic [127:0] iv);
    write_reg(REG_KEY0, key[255:192]);
    write_reg(REG_KEY1, key[191:128]);
    write_reg(REG_KEY2, key[127:64]);
    write_reg(REG_KEY3, key[63:0]);
    write_reg(REG_KEY_SIZE, {62'd0, ks});
    write_reg(REG_MODE, {62'd0, md});
    write_reg(REG_IV_HI, iv[127:64]);
    write_reg(REG_IV_LO, iv[63:0]);
  endtask

  function automatic logic [127:0] rand_block();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Result channel: random stalls, plus a long hold-off when asked.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_tready <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    cipher_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result: out_hi %h out_lo %h", out_tdata[63:0], out_tdata[127:64]);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_tdata[63:0] !== e.hi) begin
          $error("out_hi: expected %h, got %h", e.hi, out_tdata[63:0]);
          errors++;
        end
        if (out_tdata[127:64] !== e.lo) begin
          $error("out_lo: expected %h, got %h", e.lo, out_tdata[127:64]);
          errors++;
        end
        if (out_tdata[132:128] !== e.nbytes) begin
          $error("out_bytes: expected %0d, got %0d", e.nbytes, out_tdata[132:128]);
          errors++;
        end
        if (out_tuser !== e.hdr) begin
          $error("is_header: expected %b, got %b", e.hdr, out_tuser);
          errors++;
        end
        if (out_tlast !== e.fin) begin
          $error("run_end: expected %b, got %b", e.fin, out_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("aes_cbc_ctr_mode_engine regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Directed rows: FIPS-197 key, IV zero for CBC; the CTR rows start the counter at all ones.
  localparam logic [127:0] KAT_PT = 128'h00112233445566778899aabbccddeeff;
  localparam logic [127:0] KAT_CT = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
  localparam logic [127:0] ONES  = {128{1'b1}};

  stim_row_t dir_rows [] = '{
    '{MODE_CBC_ENC, KAT_PT[127:64], KAT_PT[63:0], 1'b1, 1'b0, 5'd16, 1'b1, KAT_CT},
    '{MODE_CBC_ENC, 64'd0, 64'd0, 1'b0, 1'b0, 5'd1, 1'b0, '0},
    '{MODE_CBC_ENC, ONES[127:64], ONES[63:0], 1'b0, 1'b1, 5'd16, 1'b0, '0},
    '{MODE_CBC_ENC, ONES[127:64], 64'd0, 1'b1, 1'b1, 5'd1, 1'b0, '0},
    '{MODE_CBC_ENC, 64'h0123456789abcdef, ONES[63:0], 1'b1, 1'b0, 5'd16, 1'b0, '0},
    '{MODE_CBC_ENC, 64'd0, ONES[63:0], 1'b0, 1'b1, 5'd15, 1'b0, '0},
    '{MODE_CBC_ENC, 64'hdeadbeef00000000, 64'd0, 1'b1, 1'b1, 5'd16, 1'b0, '0},
    '{MODE_CBC_DEC, KAT_CT[127:64], KAT_CT[63:0], 1'b1, 1'b0, 5'd16, 1'b1, KAT_PT},
    '{MODE_CBC_DEC, ONES[127:64], ONES[63:0], 1'b0, 1'b0, 5'd1, 1'b0, '0},
    '{MODE_CBC_DEC, 64'd0, 64'd0, 1'b0, 1'b1, 5'd16, 1'b0, '0},
    '{MODE_CBC_DEC, 64'h55aa55aa55aa55aa, 64'haa55aa55aa55aa55, 1'b1, 1'b1, 5'd8, 1'b0, '0},
    '{MODE_CTR, ONES[127:64], ONES[63:0], 1'b1, 1'b0, 5'd16, 1'b0, '0},
    '{MODE_CTR, ONES[127:64], ONES[63:0], 1'b0, 1'b1, 5'd1, 1'b0, '0},
    '{MODE_CTR, 64'd0, 64'd0, 1'b0, 1'b0, 5'd16, 1'b0, '0},
    '{MODE_CTR, ONES[127:64], ONES[63:0], 1'b0, 1'b1, 5'd15, 1'b0, '0},
    '{MODE_CTR, 64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0, 1'b1, 1'b1, 5'd8, 1'b0, '0}
  };

  // Random phase settings: key size and mode per phase.
  logic [1:0] ph_ksize [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
  logic [1:0] ph_mode  [6] = '{MODE_CBC_ENC, MODE_CBC_DEC, MODE_CTR,
                               MODE_CTR, MODE_CBC_ENC, MODE_CBC_DEC};

  initial begin
    logic [255:0] key;
    logic [127:0] iv, pt, ct, prev;
    logic [4:0]   cnt;
    logic         wf;
    logic         hold_done;
    logic         pause_done;
    int           len, ph_items, pad;

    // Build the S-boxes from the field inverse and affine map.
    for (int x = 0; x < 256; x++) begin
      logic [7:0] inv, s;
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gf_mul(inv, 8'(x));
      if (x == 0) inv = 8'h00;
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]} ^
          {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sbox[x] = s;
      inv_sbox[s] = 8'(x);
    end
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    ksize_reg = 2'd0;
    mode_reg = MODE_CBC_ENC;
    iv_reg = '0;
    chain_val = '0;
    rebuild_schedule();

    errors = 0;
    items_sent = 0;
    results_seen = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    tx_idle_pct = 9;
    rx_idle_pct = 75;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part.
    load_setting(2'd0, MODE_CBC_ENC, {128'h000102030405060708090a0b0c0d0e0f, 128'd0}, '0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != mode_reg) begin
        drain();
        write_reg(REG_MODE, {62'd0, dir_rows[i].mode});
      end
      if (dir_rows[i].mode == MODE_CTR && dir_rows[i].first) begin
        // Counter starts at all ones so it wraps on the next item.
        drain();
        write_reg(REG_IV_HI, ONES[127:64]);
        write_reg(REG_IV_LO, ONES[63:0]);
      end
      send_item({dir_rows[i].hi, dir_rows[i].lo}, dir_rows[i].first, dir_rows[i].last,
                dir_rows[i].cnt);
      if (dir_rows[i].known && last_pred !== dir_rows[i].known_blk) begin
        $error("known answer: expected %h, got %h", dir_rows[i].known_blk, last_pred);
        errors++;
      end
    end

    // Random part: well-formed messages with some noise, six settings.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph == 3) begin
        key = {256{1'b1}};
        iv = ONES;
      end else if (ph == 0) begin
        key = '0;
        iv = '0;
      end else begin
        key = {rand_block(), rand_block()};
        iv = rand_block();
      end
      load_setting(ph_ksize[ph], ph_mode[ph], key, iv);
      ph_items = 0;
      while (ph_items < 26) begin
        if (items_sent >= 76 && items_sent < 136) begin
          tx_idle_pct = 75;
          rx_idle_pct = 9;
        end else if (items_sent >= 136) begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        if (ph == 2 && ph_items >= 10 && !hold_done) begin
          hold_done = 1'b1;
          @(posedge clk);
          rx_hold_left = 400;
          @(negedge clk);
        end
        if (ph == 4 && ph_items >= 12 && !pause_done) begin
          pause_done = 1'b1;
          while (pending_q.size() != 0) @(negedge clk);
        end
        len = $urandom_range(1, 4);
        wf = ($urandom_range(99) < 85);
        prev = iv_reg;
        for (int j = 0; j < len; j++) begin
          pt = rand_block();
          cnt = (j == len - 1) ? 5'($urandom_range(1, 16)) : 5'd16;
          if (!wf) begin
            send_item(pt, 1'($urandom), 1'($urandom), 5'($urandom_range(1, 16)));
          end else if (mode_reg == MODE_CBC_DEC) begin
            // Encrypt a padded plaintext so the last block carries valid padding.
            if (j == len - 1) begin
              pad = $urandom_range(1, 16);
              for (int b = 16 - pad; b < 16; b++) pt[127-8*b -: 8] = 8'(pad);
            end
            ct = aes_encrypt(pt ^ prev);
            prev = ct;
            send_item(ct, j == 0, j == len - 1, cnt);
          end else begin
            send_item(pt, j == 0, j == len - 1, cnt);
          end
          ph_items++;
        end
      end
    end

    drain();
    $display("Covered %0d items and %0d results over CBC encrypt, CBC decrypt and CTR,",
             items_sent, results_seen);
    $display("with all three key sizes, IV and key extremes, stalls and a long hold-off.");
    if (errors == 0) begin
      $display("aes_cbc_ctr_mode_engine regression: pass");
    end else begin
      $display("aes_cbc_ctr_mode_engine regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
design/acm_pkg.sv
design/acm_ram.sv
design/acm_round.sv
design/aes_cbc_ctr_mode_engine.sv
tb/sv/aes_cbc_ctr_mode_engine_tb.sv
